// File: sv/cle_pkg.sv
// cle_pkg: shared constants for the canonical line editor
// no dependencies; used by canonical_line_editor
`default_nettype none

package cle_pkg;

  localparam int unsigned LineMaxDefault = 256;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LimitW = 9;
  localparam int unsigned GroupW = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned IndexW = 8;
  localparam int unsigned LengthW = 9;

  localparam logic [LimitW-1:0] LimitReset = 9'd256;
  localparam logic              CrlfReset  = 1'b1;
  localparam logic [GroupW-1:0] GroupReset = 16'd0;

  localparam logic [CfgIdxW-1:0] RegLineLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCrlf      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGroup     = 2'd2;

  localparam logic [ByteW-1:0] ChDel   = 8'h7F;
  localparam logic [ByteW-1:0] ChBs    = 8'h08;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChEof   = 8'h04;
  localparam logic [ByteW-1:0] ChIntr  = 8'h03;

endpackage

`default_nettype wire

// File: sv/canonical_line_editor.sv
// canonical_line_editor: line editing of received bytes with echo and buffer writes
// the accepted byte waits in the input byte register, then goes to the result registers once
// the sequencer is free; one byte per cycle for single-result bytes and one result per cycle,
// while out_ready_i holds; backspace sends BS, space, BS and cr/lf newline sends CR then LF
// reset: line count cleared, registers to their reset values, no item pending
// depends on cle_pkg
`default_nettype none

module canonical_line_editor #(
  parameter int unsigned LINE_MAX = cle_pkg::LineMaxDefault
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [cle_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [cle_pkg::CfgW-1:0]          cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire [cle_pkg::ByteW-1:0]         rx_byte_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             echo_valid_o,
  output logic [cle_pkg::ByteW-1:0]        echo_byte_o,
  output logic                             store_valid_o,
  output logic [cle_pkg::IndexW-1:0]       store_index_o,
  output logic [cle_pkg::ByteW-1:0]        store_byte_o,
  output logic                             line_done_o,
  output logic [cle_pkg::LengthW-1:0]      line_length_o,
  output logic                             kill_request_o,
  output logic [cle_pkg::GroupW-1:0]       kill_group_o,
  output logic                             last_o
);

  localparam int unsigned CntW = $clog2(LINE_MAX + 1);
  localparam int unsigned CmpW = (CntW > cle_pkg::LimitW) ? CntW : cle_pkg::LimitW;
  localparam logic [CmpW-1:0] LineMaxC = CmpW'(LINE_MAX);

  typedef enum logic [2:0] {
    KBs, KNlCrlf, KNl, KEof, KIntr, KChar
  } kind_e;

  // configuration
  logic [cle_pkg::LimitW-1:0] limit_q;
  logic                       crlf_q;
  logic [cle_pkg::GroupW-1:0] group_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= cle_pkg::LimitReset;
      crlf_q  <= cle_pkg::CrlfReset;
      group_q <= cle_pkg::GroupReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cle_pkg::RegLineLimit: limit_q <= cfg_data_i[cle_pkg::LimitW-1:0];
        cle_pkg::RegCrlf:      crlf_q  <= cfg_data_i[0];
        cle_pkg::RegGroup:     group_q <= cfg_data_i[cle_pkg::GroupW-1:0];
        default: ;
      endcase
    end
  end

  // input byte register
  logic                      hold_q;
  logic [cle_pkg::ByteW-1:0] byte_q;
  logic                      seq_valid_q;
  logic [1:0]                phase_q;
  logic                      seq_free;
  logic                      in_acc;

  assign seq_free   = !seq_valid_q || (out_ready_i && last_o);
  assign in_ready_o = !hold_q || seq_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // decode
  logic [CntW-1:0]           cnt_q, cnt_d, cnt_inc, cnt_dec;
  logic [cle_pkg::ByteW-1:0] ch;
  logic [CmpW-1:0]           lim_raw, lim_eff;
  logic                      at_limit;
  kind_e                     kind_d, kind_q;
  logic [CntW-1:0]           idx_d;
  logic [CntW-1:0]           len_d;
  logic                      done_d, emit_d;
  logic [cle_pkg::ByteW-1:0] ch_q;
  logic [cle_pkg::IndexW-1:0] idx_q;
  logic [cle_pkg::LengthW-1:0] len_q;
  logic                      done_q;
  logic [cle_pkg::GroupW-1:0] kgrp_q;

  assign ch       = (byte_q == cle_pkg::ChDel) ? cle_pkg::ChBs : byte_q;
  assign cnt_inc  = cnt_q + CntW'(1);
  assign cnt_dec  = cnt_q - CntW'(1);
  assign lim_raw  = CmpW'(limit_q);
  assign lim_eff  = (lim_raw == '0 || lim_raw > LineMaxC) ? LineMaxC : lim_raw;
  assign at_limit = CmpW'(cnt_inc) >= lim_eff;

  always_comb begin
    kind_d = KChar;
    idx_d  = cnt_q;
    len_d  = cnt_q;
    done_d = 1'b0;
    emit_d = 1'b1;
    cnt_d  = cnt_q;
    priority if (ch == cle_pkg::ChBs) begin
      kind_d = KBs;
      idx_d  = cnt_dec;
      emit_d = (cnt_q != '0);
      cnt_d  = (cnt_q != '0) ? cnt_dec : cnt_q;
    end else if (ch == cle_pkg::ChCr || ch == cle_pkg::ChLf) begin
      kind_d = crlf_q ? KNlCrlf : KNl;
      len_d  = cnt_inc;
      done_d = 1'b1;
      cnt_d  = '0;
    end else if (ch == cle_pkg::ChEof) begin
      kind_d = KEof;
      done_d = 1'b1;
      cnt_d  = '0;
    end else if (ch == cle_pkg::ChIntr) begin
      kind_d = KIntr;
      done_d = 1'b1;
      cnt_d  = '0;
    end else begin
      kind_d = KChar;
      len_d  = cnt_inc;
      done_d = at_limit;
      cnt_d  = at_limit ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= 1'b0;
      seq_valid_q <= 1'b0;
      phase_q     <= 2'd0;
      cnt_q       <= '0;
    end else begin
      if (in_acc) begin
        hold_q <= 1'b1;
      end else if (seq_free) begin
        hold_q <= 1'b0;
      end
      if (seq_free) begin
        seq_valid_q <= hold_q && emit_d;
        phase_q     <= 2'd0;
        if (hold_q) begin
          cnt_q <= cnt_d;
        end
      end else if (out_ready_i) begin
        phase_q <= phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= rx_byte_i;
    end
    if (seq_free && hold_q) begin
      kind_q <= kind_d;
      ch_q   <= ch;
      idx_q  <= cle_pkg::IndexW'(idx_d);
      len_q  <= cle_pkg::LengthW'(len_d);
      done_q <= done_d;
      kgrp_q <= group_q;
    end
  end

  // result items
  always_comb begin
    echo_valid_o   = 1'b0;
    echo_byte_o    = '0;
    store_valid_o  = 1'b0;
    store_index_o  = '0;
    store_byte_o   = '0;
    line_done_o    = 1'b0;
    line_length_o  = '0;
    kill_request_o = 1'b0;
    kill_group_o   = '0;
    last_o         = 1'b1;
    unique case (kind_q)
      KBs: begin
        echo_valid_o = 1'b1;
        echo_byte_o  = cle_pkg::ChBs;
        last_o       = (phase_q == 2'd2);
        if (phase_q == 2'd1) begin
          echo_byte_o   = cle_pkg::ChSpace;
          store_valid_o = 1'b1;
          store_index_o = idx_q;
          store_byte_o  = cle_pkg::ChSpace;
        end
      end
      KNlCrlf: begin
        echo_valid_o = 1'b1;
        if (phase_q == 2'd0) begin
          last_o        = 1'b0;
          echo_byte_o   = cle_pkg::ChCr;
          store_valid_o = 1'b1;
          store_index_o = idx_q;
          store_byte_o  = cle_pkg::ChLf;
        end else begin
          echo_byte_o   = cle_pkg::ChLf;
          line_done_o   = 1'b1;
          line_length_o = len_q;
        end
      end
      KNl: begin
        echo_valid_o  = 1'b1;
        echo_byte_o   = cle_pkg::ChLf;
        store_valid_o = 1'b1;
        store_index_o = idx_q;
        store_byte_o  = cle_pkg::ChLf;
        line_done_o   = 1'b1;
        line_length_o = len_q;
      end
      KEof: begin
        line_done_o   = 1'b1;
        line_length_o = len_q;
      end
      KIntr: begin
        line_done_o    = 1'b1;
        line_length_o  = len_q;
        kill_request_o = 1'b1;
        kill_group_o   = kgrp_q;
      end
      KChar: begin
        echo_valid_o  = 1'b1;
        echo_byte_o   = ch_q;
        store_valid_o = 1'b1;
        store_index_o = idx_q;
        store_byte_o  = ch_q;
        line_done_o   = done_q;
        line_length_o = done_q ? len_q : '0;
      end
      default: ;
    endcase
  end

  assign out_valid_o = seq_valid_q;

`ifndef ASSERT_OFF
  a_multi_item_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("result sequence broken before its last item");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> last_o)
    else $error("line end on a result that is not the last");

  a_kill_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kill_request_o |-> line_done_o)
    else $error("kill request without line end");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(cnt_q) < LineMaxC)
    else $error("line count reached the buffer size");
`endif

endmodule

`default_nettype wire
